/* sv/ffs_pkg.sv */
// ----------------------------------------------------------------------------
// ffs_pkg
// Shared types and constants of the force feedback smoother.
// ----------------------------------------------------------------------------
package ffs_pkg;

  localparam int FORCE_W    = 32;
  localparam int SPEED_W    = 24;
  localparam int TORQUE_W   = 16;
  localparam int LIMIT_W    = 31;
  localparam int WEIGHT_W   = 7;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 31;

  localparam logic [CFG_IDX_W-1:0] REG_MAX_FORCE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SMOOTHING = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_INVERT    = 2'd2;

  localparam logic [LIMIT_W-1:0]        MAX_FORCE_RESET = 31'd1280000;
  localparam logic [WEIGHT_W-1:0]       FULL_WEIGHT     = 7'd100;
  localparam logic signed [SPEED_W-1:0] SLOW_SPEED      = 24'sd6400;

  typedef enum logic [3:0] {
    S_IDLE,
    S_CLAMP,
    S_FRAC_GO,
    S_FRAC_WAIT,
    S_SCALE,
    S_SUM,
    S_AVG_GO,
    S_AVG_WAIT,
    S_STORE,
    S_OUT
  } state_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_status_t;

endpackage

/* sv/ffs_in_if.sv */
// ----------------------------------------------------------------------------
// ffs_in_if
// Telemetry sample channel: valid/ready with force and speed.
// ----------------------------------------------------------------------------
interface ffs_in_if;
  logic                                      valid;
  logic                                      ready;
  logic signed [ffs_pkg::FORCE_W-1:0]        arm_force;
  logic signed [ffs_pkg::SPEED_W-1:0]        vehicle_speed;

  modport source (output valid, output arm_force, output vehicle_speed, input ready);
  modport sink   (input valid, input arm_force, input vehicle_speed, output ready);
endinterface

/* sv/ffs_out_if.sv */
// ----------------------------------------------------------------------------
// ffs_out_if
// Result channel: valid/ready with torque fraction and force echo.
// ----------------------------------------------------------------------------
interface ffs_out_if;
  logic                                      valid;
  logic                                      ready;
  logic signed [ffs_pkg::TORQUE_W-1:0]       torque_fraction;
  logic signed [ffs_pkg::FORCE_W-1:0]        raw_force_echo;

  modport source (output valid, output torque_fraction, output raw_force_echo, input ready);
  modport sink   (input valid, input torque_fraction, input raw_force_echo, output ready);
endinterface

/* sv/ffs_divider.sv */
// ----------------------------------------------------------------------------
// ffs_divider
// Restoring divider, one quotient bit per cycle. Dividend is hi*2^FB + lo
// with hi not above the divisor, so the quotient fits in FB+1 bits.
// ----------------------------------------------------------------------------
module ffs_divider #(
  parameter int DW = 31,
  parameter int FB = 14
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [DW-1:0]               hi,
  input  logic [FB-1:0]               lo,
  input  logic [DW-1:0]               divisor,
  output ffs_pkg::div_status_t        status,
  output logic [FB:0]                 quot
);

  localparam int CNT_W = $clog2(FB + 2);

  logic [DW:0]      rem;
  logic [FB-1:0]    lo_sh;
  logic [DW-1:0]    dvs;
  logic [CNT_W-1:0] cnt;
  logic             first;
  logic             busy;
  logic             done;

  logic [DW:0]      cand;
  logic [DW:0]      diff;
  logic             ge;

  always_comb begin
    cand = first ? rem : {rem[DW-1:0], lo_sh[FB-1]};
    ge   = cand >= {1'b0, dvs};
    diff = cand - {1'b0, dvs};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(FB + 1);
      end else if (busy) begin
        cnt <= cnt - CNT_W'(1);
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem   <= {1'b0, hi};
      lo_sh <= lo;
      dvs   <= divisor;
      first <= 1'b1;
    end else if (busy) begin
      rem   <= ge ? diff : cand;
      quot  <= {quot[FB-1:0], ge};
      first <= 1'b0;
      if (!first) begin
        lo_sh <= lo_sh << 1;
      end
    end
  end

  assign status.busy = busy;
  assign status.done = done;

endmodule

/* sv/ffs_hist_mem.sv */
// ----------------------------------------------------------------------------
// ffs_hist_mem
// History window storage: one write port, one registered read port.
// ----------------------------------------------------------------------------
module ffs_hist_mem #(
  parameter int DEPTH = 20,
  parameter int DW    = 16
) (
  input  logic                      clk,
  input  logic                      rd_en,
  input  logic [$clog2(DEPTH)-1:0]  rd_addr,
  output logic [DW-1:0]             rd_data,
  input  logic                      wr_en,
  input  logic [$clog2(DEPTH)-1:0]  wr_addr,
  input  logic [DW-1:0]             wr_data
);

  logic [DW-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

/* sv/force_feedback_smoother_core.sv */
// ----------------------------------------------------------------------------
// force_feedback_smoother_core
// Clamps and normalizes steering force, then smooths it against a window of
// past fractions held in a history memory.
//
// in_ch carries arm_force and vehicle_speed; out_ch returns torque_fraction
// (2^FRACTION_BITS is full scale) and raw_force_echo. Registers are written
// through cfg_we/cfg_index/cfg_data; the user must do so only while the
// block is idle, which the block itself does not enforce. One item is in
// work at a time. With two or more fractions held an item passes through
// the single restoring divider twice, once for normalizing and once for
// the average, one quotient bit per cycle; otherwise it runs only the
// normalizing division. in_ch.ready is high again from the edge that loads
// the result into the output register, so a new item may enter while the
// last result still waits. If the receiver stalls, the finished item waits
// in the core until the output register frees up.
// Reset empties the window, clears the sum and restores register defaults;
// the history memory itself needs no clearing pass.
// ----------------------------------------------------------------------------
module force_feedback_smoother_core #(
  parameter int WINDOW_DEPTH  = 20,
  parameter int FRACTION_BITS = 14
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic [ffs_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [ffs_pkg::CFG_DATA_W-1:0]    cfg_data,
  ffs_in_if.sink                            in_ch,
  ffs_out_if.source                         out_ch
);

  localparam int AW    = $clog2(WINDOW_DEPTH);
  localparam int CW    = $clog2(WINDOW_DEPTH + 1);
  localparam int FW    = FRACTION_BITS + 2;
  localparam int SUM_W = FRACTION_BITS + CW + 1;
  localparam int PA_W  = SUM_W + 8;
  localparam int PB_W  = FW + 8;
  localparam int NUM_W = SUM_W + 9;
  localparam int DEN_W = ffs_pkg::WEIGHT_W + CW + 1;
  localparam int LW    = ffs_pkg::LIMIT_W;

  // configuration
  logic [LW-1:0]                  max_force;
  logic [ffs_pkg::WEIGHT_W-1:0]   smoothing_pct;
  logic                           invert;

  // control
  ffs_pkg::state_t                state;
  ffs_pkg::state_t                state_next;
  logic [CW-1:0]                  fill_count;
  logic [AW-1:0]                  oldest_pointer;
  logic signed [SUM_W-1:0]        history_sum;
  logic                           out_valid;

  // datapath
  logic signed [ffs_pkg::FORCE_W-1:0] force_q;
  logic signed [ffs_pkg::SPEED_W-1:0] speed_q;
  logic [LW-1:0]                  lim;
  logic [LW-1:0]                  mag;
  logic                           neg;
  logic [ffs_pkg::WEIGHT_W-1:0]   weight;
  logic signed [FW-1:0]           frac;
  logic signed [PA_W-1:0]         prod_a;
  logic signed [PB_W-1:0]         prod_b;
  logic [DEN_W-1:0]               den;
  logic [NUM_W-1:0]               num_mag;
  logic                           num_neg;
  logic signed [FW-1:0]           res;
  logic signed [ffs_pkg::TORQUE_W-1:0] torque;
  logic signed [ffs_pkg::FORCE_W-1:0]  echo;

  // fsm outputs
  logic                           in_ready;
  logic                           div_start;
  logic                           mem_wr;
  logic                           load_out;

  // combinational helpers
  logic                           in_acc;
  logic [LW-1:0]                  lim_c;
  logic [ffs_pkg::FORCE_W-1:0]    abs_f;
  logic [ffs_pkg::WEIGHT_W-1:0]   wc;
  logic signed [FW-1:0]           q_s;
  logic signed [NUM_W-1:0]        num_s;
  logic [LW-1:0]                  div_hi;
  logic [FRACTION_BITS-1:0]       div_lo;
  logic [LW-1:0]                  div_d;
  logic [CW:0]                    pos_sum;
  logic [AW-1:0]                  wr_pos;
  logic                           full;
  logic [FW-1:0]                  old_frac;

  ffs_pkg::div_status_t           div_st;
  logic [FRACTION_BITS:0]         quot;

  assign in_acc = in_ch.valid && in_ready;
  assign full   = fill_count == CW'(WINDOW_DEPTH);
  assign wc     = ffs_pkg::FULL_WEIGHT - weight;
  assign q_s    = signed'({1'b0, quot});

  always_comb begin
    lim_c   = (max_force == '0) ? LW'(1) : max_force;
    abs_f   = force_q[ffs_pkg::FORCE_W-1] ? ffs_pkg::FORCE_W'(-force_q)
                                          : ffs_pkg::FORCE_W'(force_q);
    num_s   = NUM_W'(prod_a) + NUM_W'(prod_b);
    pos_sum = (CW + 1)'(oldest_pointer) + (CW + 1)'(fill_count);
    if (pos_sum >= (CW + 1)'(WINDOW_DEPTH)) begin
      wr_pos = AW'(pos_sum - (CW + 1)'(WINDOW_DEPTH));
    end else begin
      wr_pos = AW'(pos_sum);
    end
    if (full) begin
      wr_pos = oldest_pointer;
    end
    if (state == ffs_pkg::S_AVG_GO) begin
      div_hi = LW'(num_mag[NUM_W-1:FRACTION_BITS]);
      div_lo = num_mag[FRACTION_BITS-1:0];
      div_d  = LW'(den);
    end else begin
      div_hi = mag;
      div_lo = '0;
      div_d  = lim;
    end
  end

  ffs_divider #(
    .DW (LW),
    .FB (FRACTION_BITS)
  ) u_div (
    .clk     (clk),
    .rst     (rst),
    .start   (div_start),
    .hi      (div_hi),
    .lo      (div_lo),
    .divisor (div_d),
    .status  (div_st),
    .quot    (quot)
  );

  ffs_hist_mem #(
    .DEPTH (WINDOW_DEPTH),
    .DW    (FW)
  ) u_mem (
    .clk     (clk),
    .rd_en   (in_acc),
    .rd_addr (oldest_pointer),
    .rd_data (old_frac),
    .wr_en   (mem_wr),
    .wr_addr (wr_pos),
    .wr_data (frac)
  );

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ffs_pkg::S_IDLE: begin
        if (in_ch.valid) begin
          state_next = ffs_pkg::S_CLAMP;
        end
      end
      ffs_pkg::S_CLAMP:     state_next = ffs_pkg::S_FRAC_GO;
      ffs_pkg::S_FRAC_GO:   state_next = ffs_pkg::S_FRAC_WAIT;
      ffs_pkg::S_FRAC_WAIT: begin
        if (div_st.done) begin
          state_next = (fill_count > CW'(1)) ? ffs_pkg::S_SCALE : ffs_pkg::S_STORE;
        end
      end
      ffs_pkg::S_SCALE:     state_next = ffs_pkg::S_SUM;
      ffs_pkg::S_SUM:       state_next = ffs_pkg::S_AVG_GO;
      ffs_pkg::S_AVG_GO:    state_next = ffs_pkg::S_AVG_WAIT;
      ffs_pkg::S_AVG_WAIT: begin
        if (div_st.done) begin
          state_next = ffs_pkg::S_STORE;
        end
      end
      ffs_pkg::S_STORE:     state_next = ffs_pkg::S_OUT;
      ffs_pkg::S_OUT: begin
        if (!out_valid || out_ch.ready) begin
          state_next = ffs_pkg::S_IDLE;
        end
      end
      default:              state_next = ffs_pkg::S_IDLE;
    endcase
  end

  // fsm outputs
  always_comb begin
    in_ready  = 1'b0;
    div_start = 1'b0;
    mem_wr    = 1'b0;
    load_out  = 1'b0;
    unique case (state)
      ffs_pkg::S_IDLE:     in_ready  = 1'b1;
      ffs_pkg::S_FRAC_GO,
      ffs_pkg::S_AVG_GO:   div_start = 1'b1;
      ffs_pkg::S_STORE:    mem_wr    = 1'b1;
      ffs_pkg::S_OUT:      load_out  = !out_valid || out_ch.ready;
      default: begin
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= ffs_pkg::S_IDLE;
      max_force      <= ffs_pkg::MAX_FORCE_RESET;
      smoothing_pct  <= '0;
      invert         <= 1'b0;
      fill_count     <= '0;
      oldest_pointer <= '0;
      history_sum    <= '0;
      out_valid      <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_we) begin
        unique case (cfg_index)
          ffs_pkg::REG_MAX_FORCE: max_force     <= cfg_data[LW-1:0];
          ffs_pkg::REG_SMOOTHING: smoothing_pct <= cfg_data[ffs_pkg::WEIGHT_W-1:0];
          ffs_pkg::REG_INVERT:    invert        <= cfg_data[0];
          default: begin
          end
        endcase
      end
      if (mem_wr) begin
        history_sum <= history_sum - (full ? SUM_W'(signed'(old_frac)) : SUM_W'(0))
                       + SUM_W'(frac);
        if (full) begin
          oldest_pointer <= (oldest_pointer == AW'(WINDOW_DEPTH - 1)) ? '0
                            : oldest_pointer + AW'(1);
        end else begin
          fill_count <= fill_count + CW'(1);
        end
      end
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (in_acc) begin
      force_q <= in_ch.arm_force;
      speed_q <= in_ch.vehicle_speed;
    end
    if (state == ffs_pkg::S_CLAMP) begin
      lim <= lim_c;
      mag <= (abs_f > {1'b0, lim_c}) ? lim_c : abs_f[LW-1:0];
      neg <= force_q[ffs_pkg::FORCE_W-1];
      if (speed_q < ffs_pkg::SLOW_SPEED || smoothing_pct > ffs_pkg::FULL_WEIGHT) begin
        weight <= ffs_pkg::FULL_WEIGHT;
      end else begin
        weight <= smoothing_pct;
      end
    end
    if (state == ffs_pkg::S_FRAC_WAIT && div_st.done) begin
      frac <= neg ? -q_s : q_s;
      res  <= neg ? -q_s : q_s;
    end
    if (state == ffs_pkg::S_SCALE) begin
      prod_a <= signed'({1'b0, weight}) * history_sum;
      prod_b <= signed'({1'b0, wc}) * frac;
      den    <= DEN_W'(weight) * DEN_W'(fill_count) + DEN_W'(wc);
    end
    if (state == ffs_pkg::S_SUM) begin
      num_neg <= num_s[NUM_W-1];
      num_mag <= num_s[NUM_W-1] ? NUM_W'(-num_s) : NUM_W'(num_s);
    end
    if (state == ffs_pkg::S_AVG_WAIT && div_st.done) begin
      res <= num_neg ? -q_s : q_s;
    end
    if (mem_wr && invert) begin
      res <= -res;
    end
    if (load_out) begin
      torque <= ffs_pkg::TORQUE_W'(res);
      echo   <= force_q;
    end
  end

  assign in_ch.ready            = in_ready;
  assign out_ch.valid           = out_valid;
  assign out_ch.torque_fraction = torque;
  assign out_ch.raw_force_echo  = echo;

  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill_count <= CW'(WINDOW_DEPTH))
    else $error("history fill count beyond window depth");

  a_ptr_only_when_full: assert property (@(posedge clk) disable iff (rst)
    oldest_pointer != '0 |-> full)
    else $error("oldest pointer moved before window filled");

  a_div_done_waiting: assert property (@(posedge clk) disable iff (rst)
    div_st.done |-> (state == ffs_pkg::S_FRAC_WAIT || state == ffs_pkg::S_AVG_WAIT))
    else $error("divider finished outside a wait state");

  a_load_sets_valid: assert property (@(posedge clk) disable iff (rst)
    load_out |=> out_valid)
    else $error("finished item not presented");

endmodule

/* tb/ffs_smoother_checker.sv */
// ----------------------------------------------------------------------------
// ffs_smoother_checker
// Watches the register port and both channels of the force feedback
// smoother. It keeps its own copy of the registers and the history window,
// predicts the torque fraction of every accepted sample, and compares each
// returned result, field by field, against the oldest prediction.
// ----------------------------------------------------------------------------
module ffs_smoother_checker import ffs_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  ffs_in_if                     in_ch,
  ffs_out_if                    out_ch,
  output int                    mismatches,
  output int                    pending,
  output int                    checked
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int     WINDOW     = 20;
  localparam int     FRAC_BITS  = 14;
  localparam longint FULL_SCALE = longint'(1) << FRAC_BITS;

  typedef struct packed {
    logic signed [TORQUE_W-1:0] torque;
    logic signed [FORCE_W-1:0]  echo;
  } torque_item_t;

  torque_item_t torque_due_q[$];

  logic [LIMIT_W-1:0]  max_force_r;
  logic [WEIGHT_W-1:0] smooth_r;
  logic                invert_r;

  longint window [WINDOW];
  longint window_sum;
  int     fill_cnt;
  int     oldest;

  function automatic logic signed [TORQUE_W-1:0] smooth_sample(
    logic signed [FORCE_W-1:0] arm,
    logic signed [SPEED_W-1:0] spd
  );
    longint lim, clamped, frac, w, wc, res;
    int     slot;
    lim = (max_force_r == '0) ? longint'(1) : longint'(max_force_r);
    clamped = arm;
    if (clamped > lim) begin
      clamped = lim;
    end else if (clamped < -lim) begin
      clamped = -lim;
    end
    frac = (clamped * FULL_SCALE) / lim;
    if (fill_cnt > 1) begin
      w = (smooth_r > FULL_WEIGHT) ? FULL_WEIGHT : smooth_r;
      if (spd < SLOW_SPEED) begin
        w = FULL_WEIGHT;
      end
      wc  = longint'(FULL_WEIGHT) - w;
      res = (w * window_sum + wc * frac) / (w * longint'(fill_cnt) + wc);
    end else begin
      res = frac;
    end
    // full window drops its oldest fraction first
    if (fill_cnt >= WINDOW) begin
      window_sum     -= window[oldest];
      window[oldest]  = frac;
      oldest          = (oldest + 1) % WINDOW;
    end else begin
      slot         = (oldest + fill_cnt) % WINDOW;
      window[slot] = frac;
      fill_cnt++;
    end
    window_sum += frac;
    if (invert_r) begin
      res = -res;
    end
    return res[TORQUE_W-1:0];
  endfunction

  always @(posedge clk) begin : watch
    torque_item_t want;
    if (rst) begin
      max_force_r = MAX_FORCE_RESET;
      smooth_r    = '0;
      invert_r    = 1'b0;
      window_sum  = 0;
      fill_cnt    = 0;
      oldest      = 0;
      mismatches  = 0;
      checked     = 0;
      torque_due_q.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_MAX_FORCE: max_force_r = cfg_data[LIMIT_W-1:0];
          REG_SMOOTHING: smooth_r    = cfg_data[WEIGHT_W-1:0];
          REG_INVERT:    invert_r    = cfg_data[0];
          default: ;
        endcase
      end
      if (out_ch.valid && out_ch.ready) begin
        if (torque_due_q.size() == 0) begin
          $error("result with no item waiting: torque_fraction %0d raw_force_echo %0d",
                 out_ch.torque_fraction, out_ch.raw_force_echo);
          mismatches++;
        end else begin
          want = torque_due_q.pop_front();
          if (out_ch.torque_fraction !== want.torque) begin
            $error("torque_fraction mismatch: expected %0d, actual %0d",
                   want.torque, out_ch.torque_fraction);
            mismatches++;
          end
          if (out_ch.raw_force_echo !== want.echo) begin
            $error("raw_force_echo mismatch: expected %0d, actual %0d",
                   want.echo, out_ch.raw_force_echo);
            mismatches++;
          end
          checked++;
        end
      end
      if (in_ch.valid && in_ch.ready) begin
        want.torque = smooth_sample(in_ch.arm_force, in_ch.vehicle_speed);
        want.echo   = in_ch.arm_force;
        torque_due_q.push_back(want);
      end
    end
    pending = torque_due_q.size();
  end

endmodule

/* tb/force_feedback_smoother_core_tb.sv */
// ----------------------------------------------------------------------------
// force_feedback_smoother_core_tb
// Drives telemetry samples into the smoother core: a short list of edge
// cases at reset settings, then random samples over eight register
// settings including the clamp and weight extremes, with sender and
// receiver stalls in three patterns. A checker beside the core predicts
// and compares every result.
// ----------------------------------------------------------------------------
module force_feedback_smoother_core_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import ffs_pkg::*;

  localparam int PHASES       = 8;
  localparam int PHASE_ITEMS  = 240;
  localparam int SETTLE       = 48;
  localparam int LIMIT_CYCLES = 1000000;

  logic                  clk;
  logic                  rst;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  ffs_in_if  in_ch ();
  ffs_out_if out_ch ();

  int mismatches, pending, checked;
  int send_idle, recv_idle;
  int n_sent, n_directed, n_settings;
  int cycles;
  int unsigned cur_limit;

  force_feedback_smoother_core u_top (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_ch     (in_ch),
    .out_ch    (out_ch)
  );

  ffs_smoother_checker u_checker (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_ch      (in_ch),
    .out_ch     (out_ch),
    .mismatches (mismatches),
    .pending    (pending),
    .checked    (checked)
  );

  always #5 clk = ~clk;

  always @(negedge clk) begin
    out_ch.ready <= ($urandom_range(0, 99) >= recv_idle);
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= LIMIT_CYCLES) begin
      $display("FAIL");
      $finish;
    end
  end

  // entered just after a falling edge; leaves valid high after the item
  task automatic send_sample(logic signed [FORCE_W-1:0] f, logic signed [SPEED_W-1:0] s);
    while ($urandom_range(0, 99) < send_idle) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid         <= 1'b1;
    in_ch.arm_force     <= f;
    in_ch.vehicle_speed <= s;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    n_sent++;
    @(negedge clk);
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  task automatic set_registers(logic [LIMIT_W-1:0] mf, logic [WEIGHT_W-1:0] sm, logic inv);
    cfg_we    <= 1'b1;
    cfg_index <= REG_MAX_FORCE;
    cfg_data  <= CFG_DATA_W'(mf);
    @(negedge clk);
    cfg_index <= REG_SMOOTHING;
    cfg_data  <= CFG_DATA_W'(sm);
    @(negedge clk);
    cfg_index <= REG_INVERT;
    cfg_data  <= CFG_DATA_W'(inv);
    @(negedge clk);
    cfg_we    <= 1'b0;
    cur_limit  = (mf == '0) ? 1 : mf;
    n_settings++;
  endtask

  function automatic logic [FORCE_W-1:0] pick_force(int unsigned lim);
    logic [FORCE_W-1:0] mag;
    case ($urandom_range(0, 7))
      0, 1: return $urandom;
      2: return $urandom_range(0, 1) ? 32'h7fff_ffff : 32'h8000_0000;
      3: mag = FORCE_W'(lim) - 2 + $urandom_range(0, 4);
      4: mag = $urandom_range(0, 1000);
      default: mag = $urandom_range(0, lim);
    endcase
    return $urandom_range(0, 1) ? -mag : mag;
  endfunction

  function automatic logic [SPEED_W-1:0] pick_speed();
    case ($urandom_range(0, 9))
      0, 1: return SPEED_W'($urandom);
      2: return SPEED_W'(SLOW_SPEED - 4 + $urandom_range(0, 8));
      3: return SPEED_W'($urandom_range(8388608, 16777215));
      default: return SPEED_W'($urandom_range(6400, 8388607));
    endcase
  endfunction

  task automatic directed_samples();
    send_sample(0, 0);
    send_sample(1280000, 6400);
    send_sample(-1280000, 6399);
    send_sample(32'sh7fff_ffff, 24'sh7f_ffff);
    send_sample(32'sh8000_0000, 24'sh80_0000);
    send_sample(1280001, 6400);
    send_sample(-1280001, -1);
    send_sample(-1, 6400);
    send_sample(78, 6401);
    send_sample(79, 6401);
    send_sample(-79, 25);
    send_sample(640000, 100000);
    send_sample(-640000, -6400);
    send_sample(12345678, 6400);
    send_sample(-5, 0);
    send_sample(320000, 8388607);
    send_sample(-960000, 6400);
    send_sample(1000, 12800);
    send_sample(-1000, 6399);
    send_sample(1279999, 6400);
    send_sample(-1279999, 6400);
    send_sample(0, 6400);
  endtask

  initial begin
    clk                  = 1'b0;
    rst                  = 1'b1;
    cfg_we               = 1'b0;
    cfg_index            = '0;
    cfg_data             = '0;
    in_ch.valid          = 1'b0;
    in_ch.arm_force      = '0;
    in_ch.vehicle_speed  = '0;
    out_ch.ready         = 1'b0;
    cycles               = 0;
    n_sent               = 0;
    n_settings           = 0;
    cur_limit            = MAX_FORCE_RESET;
    send_idle            = 37;
    recv_idle            = 80;
    repeat (5) @(negedge clk);
    rst <= 1'b0;

    // reset settings first, then the window fills past its depth
    directed_samples();
    n_directed = n_sent;
    drain();

    for (int p = 0; p < PHASES; p++) begin
      if (p == 3) begin
        send_idle = 80;
        recv_idle = 37;
      end else if (p == 6) begin
        send_idle = 0;
        recv_idle = 0;
      end
      case (p)
        0: set_registers(MAX_FORCE_RESET, 7'd50, 1'b0);
        1: set_registers(31'd1, FULL_WEIGHT, 1'b1);
        2: set_registers(31'h7fff_ffff, 7'd0, 1'b0);
        3: set_registers(31'd0, 7'h7f, 1'b1);
        4: set_registers(LIMIT_W'($urandom_range(1, 32'h7fff_ffff)),
                         WEIGHT_W'($urandom_range(0, 100)), 1'($urandom_range(0, 1)));
        5: set_registers(LIMIT_W'($urandom_range(1, 4096)),
                         WEIGHT_W'($urandom_range(0, 127)), 1'($urandom_range(0, 1)));
        6: set_registers(31'd1000000, 7'd75, 1'b1);
        default: set_registers(LIMIT_W'($urandom_range(1, 32'h7fff_ffff)),
                               WEIGHT_W'($urandom_range(0, 100)), 1'b0);
      endcase
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        send_sample(pick_force(cur_limit), pick_speed());
      end
      drain();
    end

    $display("covered %0d samples (%0d directed) over %0d register settings",
             n_sent, n_directed, n_settings + 1);
    $display("compared %0d results under three stall patterns", checked);
    if (mismatches == 0 && pending == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

/* filelist.f */
sv/ffs_pkg.sv
sv/ffs_in_if.sv
sv/ffs_out_if.sv
sv/ffs_divider.sv
sv/ffs_hist_mem.sv
sv/force_feedback_smoother_core.sv
tb/ffs_smoother_checker.sv
tb/force_feedback_smoother_core_tb.sv
